// ----- rtl/revolution_mesh_vertex_face_gen_defines.svh -----
// Assertion macros shared by the lathe mesh generator RTL.
`ifndef REVOLUTION_MESH_VERTEX_FACE_GEN_DEFINES_SVH
`define REVOLUTION_MESH_VERTEX_FACE_GEN_DEFINES_SVH

`define RMVF_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("rmvf assertion failed");

`define RMVF_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("rmvf assertion failed");

`endif

// ----- rtl/rmvf_pkg.sv -----
// Shared constants and types of the lathe mesh generator.
package rmvf_pkg;

  localparam int MAX_PROFILE = 256;
  localparam int MAX_STEPS   = 256;
  localparam int LatSc       = 16;

  localparam logic [1:0] CFG_AXIS    = 2'd0;
  localparam logic [1:0] CFG_STEPS   = 2'd1;
  localparam logic [1:0] CFG_PROFILE = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [16:0] cosv;
    logic signed [16:0] sinv;
  } sc_t;

endpackage

// ----- rtl/rmvf_sincos.sv -----
// Pipelined binary-angle divider and CORDIC giving cosine and sine of 2*pi*j/N.
`include "revolution_mesh_vertex_face_gen_defines.svh"

module rmvf_sincos
  import rmvf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] step_i,
  input  logic [8:0] steps_i,
  output logic       valid_o,
  output sc_t        sc_o
);

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [31:0] z;
    logic [1:0]         quad;
    logic               zero;
  } cordic_t;

  function automatic logic [31:0] atan_val(int unsigned k);
    case (k)
      0:  atan_val = 32'd536870912;
      1:  atan_val = 32'd316933406;
      2:  atan_val = 32'd167458907;
      3:  atan_val = 32'd85004756;
      4:  atan_val = 32'd42667331;
      5:  atan_val = 32'd21354465;
      6:  atan_val = 32'd10679838;
      7:  atan_val = 32'd5340245;
      8:  atan_val = 32'd2670163;
      9:  atan_val = 32'd1335087;
      10: atan_val = 32'd667544;
      11: atan_val = 32'd333772;
      12: atan_val = 32'd166886;
      13: atan_val = 32'd83443;
      14: atan_val = 32'd41722;
      15: atan_val = 32'd20861;
      16: atan_val = 32'd10430;
      17: atan_val = 32'd5215;
      18: atan_val = 32'd2608;
      19: atan_val = 32'd1304;
      default: atan_val = 32'd0;
    endcase
  endfunction

  function automatic cordic_t cordic_step(cordic_t a, int unsigned k);
    cordic_t r;
    r = a;
    if (!a.z[31]) begin
      r.x = a.x - (a.y >>> k);
      r.y = a.y + (a.x >>> k);
      r.z = a.z - $signed(atan_val(k));
    end else begin
      r.x = a.x + (a.y >>> k);
      r.y = a.y - (a.x >>> k);
      r.z = a.z + $signed(atan_val(k));
    end
    return r;
  endfunction

  function automatic logic [16:0] div_step8(logic [8:0] r, logic [7:0] d, logic [8:0] n);
    logic [9:0] t;
    logic [8:0] rr;
    logic [7:0] q;
    rr = r;
    q  = '0;
    for (int b = 7; b >= 0; b--) begin
      t = {rr, d[b]};
      if (t >= {1'b0, n}) begin
        t    = t - {1'b0, n};
        q[b] = 1'b1;
      end
      rr = t[8:0];
    end
    return {q, rr};
  endfunction

  function automatic logic signed [16:0] trig_round(logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd16384) >>> 15;
    if (t > 34'sd32768) begin
      return 17'sd32768;
    end else if (t < -34'sd32768) begin
      return -17'sd32768;
    end
    return t[16:0];
  endfunction

  logic        dv_q [5];
  logic [8:0]  dr_q [5];
  logic [31:0] dq_q [5];
  logic [8:0]  dr_d [5];
  logic [31:0] dq_d [5];
  logic [16:0] dstep [5];

  cordic_t     c_q [10];
  cordic_t     c_d [10];
  logic        cv_q [10];
  cordic_t     init;

  logic               v_q;
  sc_t                sc_q, sc_d;
  logic signed [16:0] cr, sr;

  always_comb begin
    dstep[0] = div_step8(9'd0, step_i, steps_i);
    dr_d[0]  = dstep[0][8:0];
    dq_d[0]  = '0;
    for (int k = 1; k < 5; k++) begin
      dstep[k] = div_step8(dr_q[k-1], 8'd0, steps_i);
      dr_d[k]  = dstep[k][8:0];
      dq_d[k]  = {dq_q[k-1][23:0], dstep[k][16:9]};
    end
  end

  always_comb begin
    init.x    = 34'sd652032874;
    init.y    = '0;
    init.z    = {2'b00, dq_q[4][29:0]};
    init.quad = dq_q[4][31:30];
    init.zero = (dq_q[4][29:0] == 30'd0);
    c_d[0] = cordic_step(cordic_step(init, 0), 1);
    for (int s = 1; s < 10; s++) begin
      c_d[s] = cordic_step(cordic_step(c_q[s-1], 2 * s), 2 * s + 1);
    end
  end

  always_comb begin
    if (c_q[9].zero) begin
      cr = 17'sd32768;
      sr = '0;
    end else begin
      cr = trig_round(c_q[9].x);
      sr = trig_round(c_q[9].y);
    end
    case (c_q[9].quad)
      2'd0: begin
        sc_d.cosv = cr;
        sc_d.sinv = sr;
      end
      2'd1: begin
        sc_d.cosv = -sr;
        sc_d.sinv = cr;
      end
      2'd2: begin
        sc_d.cosv = -cr;
        sc_d.sinv = -sr;
      end
      default: begin
        sc_d.cosv = sr;
        sc_d.sinv = -cr;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 5; k++) dv_q[k] <= 1'b0;
      for (int s = 0; s < 10; s++) cv_q[s] <= 1'b0;
      v_q <= 1'b0;
    end else begin
      dv_q[0] <= valid_i;
      for (int k = 1; k < 5; k++) dv_q[k] <= dv_q[k-1];
      cv_q[0] <= dv_q[4];
      for (int s = 1; s < 10; s++) cv_q[s] <= cv_q[s-1];
      v_q <= cv_q[9];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 5; k++) begin
      dr_q[k] <= dr_d[k];
      dq_q[k] <= dq_d[k];
    end
    for (int s = 0; s < 10; s++) c_q[s] <= c_d[s];
    sc_q <= sc_d;
  end

  assign valid_o = v_q;
  assign sc_o    = sc_q;

  `RMVF_ASSERT_IMP(a_sc_latency, valid_o, $past(valid_i, LatSc))
  `RMVF_ASSERT_IMP(a_sc_range, valid_o, sc_o.cosv <= 17'sd32768 && sc_o.cosv >= -17'sd32768 && sc_o.sinv <= 17'sd32768 && sc_o.sinv >= -17'sd32768)
  `RMVF_ASSERT_NXT(a_sc_axis, cv_q[9] && c_q[9].zero, valid_o && (sc_o.cosv == 17'sd0 || sc_o.sinv == 17'sd0))

endmodule

// ----- rtl/revolution_mesh_vertex_face_gen.sv -----
// Top level of the lathe mesh generator: config registers, index math, rotation.
`include "revolution_mesh_vertex_face_gen_defines.svh"

// Takes one profile point per clock and never asserts busy. Each point's result
// is strobed on done_o in order, one per point, after passing through the
// five-stage angle divider, the ten-stage CORDIC, the quadrant fold stage, the
// multiply stage and the round/saturate output stage. Results must be taken as
// they come. Write configuration only while no point is in flight.
module revolution_mesh_vertex_face_gen
  import rmvf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [23:0] coord_x_i,
  input  logic signed [23:0] coord_y_i,
  input  logic signed [23:0] coord_z_i,
  input  logic [7:0]         point_index_i,
  input  logic [7:0]         step_index_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i,
  output logic               done_o,
  output logic signed [23:0] rot_x_o,
  output logic signed [23:0] rot_y_o,
  output logic signed [23:0] rot_z_o,
  output logic [15:0]        vertex_index_o,
  output logic               faces_valid_o,
  output logic [15:0]        tri0_a_o,
  output logic [15:0]        tri0_b_o,
  output logic [15:0]        tri0_c_o,
  output logic [15:0]        tri1_a_o,
  output logic [15:0]        tri1_b_o,
  output logic [15:0]        tri1_c_o
);

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [15:0]        vidx;
    logic               faces;
    logic [15:0]        wnext;
  } pl_t;

  function automatic logic signed [23:0] sat_round(logic signed [41:0] v);
    logic signed [41:0] t;
    t = (v + 42'sd16384) >>> 15;
    if (t > 42'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (t < -42'sd8388608) begin
      return 24'sh800000;
    end
    return t[23:0];
  endfunction

  logic [1:0] axis_q;
  logic [8:0] steps_q, prof_q;
  logic [8:0] n_c, tam_c, nj;
  logic [16:0] vfull, wfull;
  logic        acc;
  pl_t         pl_d;
  pl_t         pl_q [LatSc];
  logic        plv_q [LatSc];

  logic        sc_v;
  sc_t         sc;

  logic signed [23:0] p, q, pass;
  logic               mv_q;
  logic signed [40:0] cp_q, sq_q, cq_q, sp_q;
  logic signed [23:0] pass_q;
  pl_t                mpl_q;

  logic signed [41:0] psum, qsum;
  logic signed [23:0] pr, qr;

  logic               done_q;
  logic signed [23:0] rx_q, ry_q, rz_q;
  logic [15:0]        vidx_q, t0a_q, t0b_q, t0c_q, t1a_q, t1b_q, t1c_q;
  logic               faces_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign acc         = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q  <= AXIS_Y;
      steps_q <= 9'd16;
      prof_q  <= 9'd4;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_AXIS:    axis_q  <= cfg_data_i[1:0];
        CFG_STEPS:   steps_q <= cfg_data_i;
        CFG_PROFILE: prof_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    n_c   = (steps_q < 9'd3) ? 9'd3 :
            ((steps_q > 9'(MAX_STEPS)) ? 9'(MAX_STEPS) : steps_q);
    tam_c = (prof_q < 9'd2) ? 9'd2 :
            ((prof_q > 9'(MAX_PROFILE)) ? 9'(MAX_PROFILE) : prof_q);
    nj    = (({1'b0, step_index_i} + 9'd1) < n_c) ? ({1'b0, step_index_i} + 9'd1) : 9'd0;
    vfull = 17'(step_index_i) * 17'(tam_c) + 17'(point_index_i);
    wfull = 17'(nj) * 17'(tam_c) + 17'(point_index_i);
    pl_d.x     = coord_x_i;
    pl_d.y     = coord_y_i;
    pl_d.z     = coord_z_i;
    pl_d.vidx  = vfull[15:0];
    pl_d.faces = (({1'b0, point_index_i} + 9'd1) < tam_c);
    pl_d.wnext = wfull[15:0];
  end

  rmvf_sincos u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc),
    .step_i  (step_index_i),
    .steps_i (n_c),
    .valid_o (sc_v),
    .sc_o    (sc)
  );

  always_comb begin
    case (axis_q)
      AXIS_X: begin
        p    = pl_q[LatSc-1].y;
        q    = pl_q[LatSc-1].z;
        pass = pl_q[LatSc-1].x;
      end
      AXIS_Z: begin
        p    = pl_q[LatSc-1].x;
        q    = pl_q[LatSc-1].y;
        pass = pl_q[LatSc-1].z;
      end
      default: begin
        p    = pl_q[LatSc-1].z;
        q    = pl_q[LatSc-1].x;
        pass = pl_q[LatSc-1].y;
      end
    endcase
  end

  always_comb begin
    psum = cp_q - sq_q;
    qsum = cq_q + sp_q;
    pr   = sat_round(psum);
    qr   = sat_round(qsum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LatSc; k++) plv_q[k] <= 1'b0;
      mv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      plv_q[0] <= acc;
      for (int k = 1; k < LatSc; k++) plv_q[k] <= plv_q[k-1];
      mv_q   <= sc_v;
      done_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q[0] <= pl_d;
    for (int k = 1; k < LatSc; k++) pl_q[k] <= pl_q[k-1];
    cp_q   <= sc.cosv * p;
    sq_q   <= sc.sinv * q;
    cq_q   <= sc.cosv * q;
    sp_q   <= sc.sinv * p;
    pass_q <= pass;
    mpl_q  <= pl_q[LatSc-1];
    case (axis_q)
      AXIS_X: begin
        rx_q <= pass_q;
        ry_q <= pr;
        rz_q <= qr;
      end
      AXIS_Z: begin
        rx_q <= pr;
        ry_q <= qr;
        rz_q <= pass_q;
      end
      default: begin
        rx_q <= qr;
        ry_q <= pass_q;
        rz_q <= pr;
      end
    endcase
    vidx_q  <= mpl_q.vidx;
    faces_q <= mpl_q.faces;
    if (mpl_q.faces) begin
      t0a_q <= mpl_q.vidx;
      t0b_q <= mpl_q.wnext;
      t0c_q <= mpl_q.wnext + 16'd1;
      t1a_q <= mpl_q.wnext + 16'd1;
      t1b_q <= mpl_q.vidx + 16'd1;
      t1c_q <= mpl_q.vidx;
    end else begin
      t0a_q <= '0;
      t0b_q <= '0;
      t0c_q <= '0;
      t1a_q <= '0;
      t1b_q <= '0;
      t1c_q <= '0;
    end
  end

  assign done_o         = done_q;
  assign rot_x_o        = rx_q;
  assign rot_y_o        = ry_q;
  assign rot_z_o        = rz_q;
  assign vertex_index_o = vidx_q;
  assign faces_valid_o  = faces_q;
  assign tri0_a_o       = t0a_q;
  assign tri0_b_o       = t0b_q;
  assign tri0_c_o       = t0c_q;
  assign tri1_a_o       = t1a_q;
  assign tri1_b_o       = t1b_q;
  assign tri1_c_o       = t1c_q;

  `RMVF_ASSERT_IMP(a_tri_zero, done_o && !faces_valid_o, {tri0_a_o, tri0_b_o, tri0_c_o, tri1_a_o, tri1_b_o, tri1_c_o} == '0)
  `RMVF_ASSERT_IMP(a_align, 1'b1, sc_v == plv_q[LatSc-1])
  `RMVF_ASSERT_IMP(a_latency, done_o, $past(start_i, LatSc + 2))

endmodule
